// ===== rtl/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg: shared widths, constants and cell payload types
// Types used between the circle collision front end, the root and divide
// cells and the top level.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int CoordW   = 24;
	localparam int RadW     = 22;
	localparam int DiffW    = 26;              // center difference, signed
	localparam int MagW     = 25;              // |difference|
	localparam int SqW      = 2 * MagW + 1;    // dx^2 + dy^2
	localparam int RootW    = 26;              // floor(sqrt) of SqW bits
	localparam int RsumW    = RadW + 1;
	localparam int NormW    = 16;
	localparam int PenW     = 24;
	localparam int QuoW     = 16;              // quotient bits of the normal divide
	localparam int NumW     = MagW + 15;       // m * 32768
	localparam int NormalOne = 16384;
	localparam int CoinPen   = -256;

	// pair data travelling through the root cells
	typedef struct packed {
		logic             valid;
		logic             coin;
		logic             hit;
		logic             sx;      // dx negative
		logic             sy;
		logic [MagW-1:0]  mx;
		logic [MagW-1:0]  my;
		logic [RsumW-1:0] rsum;
	} pair_t;

	// root iteration state
	typedef struct packed {
		logic [SqW+1:0]   rem;
		logic [RootW-1:0] root;
	} root_t;

	// divide iteration state for one axis
	typedef struct packed {
		logic [RootW+1:0] rem;
		logic [NumW-1:0]  num;
		logic [QuoW:0]    quo;
	} div_t;

endpackage

// ===== rtl/ccc_root_cell.sv =====
// ----------------------------------------------------------------------------
// ccc_root_cell: one bit of the integer square root
// Restoring digit-by-digit root: brings down two bits of the radicand and
// decides one root bit, then hands everything to the next cell.
// ----------------------------------------------------------------------------
module ccc_root_cell #(
	parameter int Step = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ccc_pkg::pair_t   pair_in,
	input  ccc_pkg::root_t   rt_in,
	input  logic [ccc_pkg::SqW-1:0] sq_in,
	output ccc_pkg::pair_t   pair_s1,
	output ccc_pkg::root_t   rt_s1,
	output logic [ccc_pkg::SqW-1:0] sq_s1
);
	localparam int Pos = 2 * (ccc_pkg::RootW - 1 - Step);

	logic [ccc_pkg::SqW:0]   sq_ext;
	logic [ccc_pkg::SqW+1:0] rem_sh;
	logic [ccc_pkg::SqW+1:0] trial;
	logic [1:0]              pair_bits;
	ccc_pkg::root_t          nxt;

	always_comb begin
		// pad the odd-width radicand so the top cell reads a zero high bit
		sq_ext    = {1'b0, sq_in};
		pair_bits = sq_ext[Pos +: 2];
		rem_sh = {rt_in.rem[ccc_pkg::SqW-1:0], pair_bits};
		trial  = {{(ccc_pkg::SqW - ccc_pkg::RootW){1'b0}}, rt_in.root, 2'b01};
		nxt    = rt_in;
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {rt_in.root[ccc_pkg::RootW-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {rt_in.root[ccc_pkg::RootW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_s1 <= '0;
		end else if (adv) begin
			pair_s1 <= pair_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_s1 <= nxt;
			sq_s1 <= sq_in;
		end
	end

endmodule

// ===== rtl/ccc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ccc_div_cell: one quotient bit of both normal components
// Restoring division of m*32768 + L by 2L, one bit per cell for x and y.
// ----------------------------------------------------------------------------
module ccc_div_cell #(
	parameter int Step = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  ccc_pkg::pair_t pair_in,
	input  logic [ccc_pkg::RootW-1:0] len_in,
	input  ccc_pkg::div_t  dx_in,
	input  ccc_pkg::div_t  dy_in,
	output ccc_pkg::pair_t pair_s1,
	output logic [ccc_pkg::RootW-1:0] len_s1,
	output ccc_pkg::div_t  dx_s1,
	output ccc_pkg::div_t  dy_s1
);
	localparam int Pos = ccc_pkg::NumW - 1 - Step;

	function automatic ccc_pkg::div_t div_step(ccc_pkg::div_t d,
		logic [ccc_pkg::RootW-1:0] len);
		logic [ccc_pkg::RootW+1:0] sh;
		logic [ccc_pkg::RootW+1:0] dv;
		ccc_pkg::div_t             r;
		r  = d;
		sh = {d.rem[ccc_pkg::RootW:0], d.num[Pos]};
		dv = {1'b0, len, 1'b0};
		if (sh >= dv) begin
			r.rem = sh - dv;
			r.quo = {d.quo[ccc_pkg::QuoW-1:0], 1'b1};
		end else begin
			r.rem = sh;
			r.quo = {d.quo[ccc_pkg::QuoW-1:0], 1'b0};
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_s1 <= '0;
		end else if (adv) begin
			pair_s1 <= pair_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s1 <= len_in;
			dx_s1  <= div_step(dx_in, len_in);
			dy_s1  <= div_step(dy_in, len_in);
		end
	end

endmodule

// ===== rtl/circle_circle_collision.sv =====
// ----------------------------------------------------------------------------
// circle_circle_collision: circle pair overlap with push normal and depth
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one circle pair per transaction.
// Output channel: out_valid/out_stall carry hit, normal_x, normal_y and
// penetration, one result per pair, in order.
// The pair passes a front stage (centers, difference, squares), a second
// stage (sum of squares, hit compare), a row of 26 square-root cells (one
// root bit each), a row of 40 divide cells (one quotient bit each, both
// axes at once), and a rounding/output register.
// The path holds 69 register stages. Throughput: one pair per cycle while
// the output is not stalled; every cell hands its data on whenever the row
// advances. The whole row advances together, so while the output register
// holds a stalled result every stage freezes and in_stall follows.
// Reset clears all valid flags; the row is empty and the block accepts a
// pair as soon as reset is released.
// ----------------------------------------------------------------------------
module circle_circle_collision (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [ccc_pkg::CoordW-1:0] a_left,
	input  logic signed [ccc_pkg::CoordW-1:0] a_top,
	input  logic [ccc_pkg::RadW-1:0]          a_radius,
	input  logic signed [ccc_pkg::CoordW-1:0] b_left,
	input  logic signed [ccc_pkg::CoordW-1:0] b_top,
	input  logic [ccc_pkg::RadW-1:0]          b_radius,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output logic signed [ccc_pkg::NormW-1:0] normal_x,
	output logic signed [ccc_pkg::NormW-1:0] normal_y,
	output logic signed [ccc_pkg::PenW-1:0]  penetration
);
	localparam int DW = ccc_pkg::DiffW;
	localparam int MW = ccc_pkg::MagW;
	localparam int SW = ccc_pkg::SqW;
	localparam int RootCells = ccc_pkg::RootW;
	localparam int DivCells  = ccc_pkg::NumW;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: difference, magnitudes, squares
	logic signed [DW-1:0] dx_c, dy_c;
	logic [MW-1:0]        mx_c, my_c;
	logic                 v_s1, sx_s1, sy_s1;
	logic [MW-1:0]        mx_s1, my_s1;
	logic [2*MW-1:0]      qx_s1, qy_s1;
	logic [ccc_pkg::RsumW-1:0] rsum_s1;

	always_comb begin
		dx_c = (DW'(a_left) + DW'({1'b0, a_radius})) - (DW'(b_left) + DW'({1'b0, b_radius}));
		dy_c = (DW'(a_top) + DW'({1'b0, a_radius})) - (DW'(b_top) + DW'({1'b0, b_radius}));
		mx_c = dx_c[DW-1] ? MW'(-dx_c) : MW'(dx_c);
		my_c = dy_c[DW-1] ? MW'(-dy_c) : MW'(dy_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1   <= dx_c[DW-1];
			sy_s1   <= dy_c[DW-1];
			mx_s1   <= mx_c;
			my_s1   <= my_c;
			qx_s1   <= mx_c * mx_c;
			qy_s1   <= my_c * my_c;
			rsum_s1 <= {1'b0, a_radius} + {1'b0, b_radius};
		end
	end

	// stage 2: sum of squares and hit compare
	logic [SW-1:0]             sq_c;
	logic [2*ccc_pkg::RsumW-1:0] r2_c;
	ccc_pkg::pair_t            pair_s2;
	logic [SW-1:0]             sq_s2;

	assign sq_c = SW'(qx_s1) + SW'(qy_s1);
	assign r2_c = rsum_s1 * rsum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_s2 <= '0;
		end else if (adv) begin
			pair_s2.valid <= v_s1;
			pair_s2.coin  <= (sq_c == '0);
			pair_s2.hit   <= (sq_c < SW'(r2_c));
			pair_s2.sx    <= sx_s1;
			pair_s2.sy    <= sy_s1;
			pair_s2.mx    <= mx_s1;
			pair_s2.my    <= my_s1;
			pair_s2.rsum  <= rsum_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2 <= sq_c;
		end
	end

	// square-root row
	ccc_pkg::pair_t rp [RootCells+1];
	ccc_pkg::root_t rr [RootCells+1];
	logic [SW-1:0]  rs [RootCells+1];

	assign rp[0] = pair_s2;
	assign rr[0] = '0;
	assign rs[0] = sq_s2;

	for (genvar i = 0; i < RootCells; i++) begin : g_root
		ccc_root_cell #(.Step(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.pair_in(rp[i]), .rt_in(rr[i]), .sq_in(rs[i]),
			.pair_s1(rp[i+1]), .rt_s1(rr[i+1]), .sq_s1(rs[i+1])
		);
	end

	// divide row
	ccc_pkg::pair_t dp [DivCells+1];
	logic [ccc_pkg::RootW-1:0] dl [DivCells+1];
	ccc_pkg::div_t  ddx [DivCells+1];
	ccc_pkg::div_t  ddy [DivCells+1];

	always_comb begin
		dp[0]      = rp[RootCells];
		dl[0]      = (rr[RootCells].root == '0) ? ccc_pkg::RootW'(1) : rr[RootCells].root;
		ddx[0]     = '0;
		ddy[0]     = '0;
		// numerator m*32768 + L; fold L in by pre-loading the sum
		ddx[0].num = {rp[RootCells].mx, 15'd0} + ccc_pkg::NumW'(dl[0]);
		ddy[0].num = {rp[RootCells].my, 15'd0} + ccc_pkg::NumW'(dl[0]);
	end

	for (genvar j = 0; j < DivCells; j++) begin : g_div
		ccc_div_cell #(.Step(j)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.pair_in(dp[j]), .len_in(dl[j]), .dx_in(ddx[j]), .dy_in(ddy[j]),
			.pair_s1(dp[j+1]), .len_s1(dl[j+1]), .dx_s1(ddx[j+1]), .dy_s1(ddy[j+1])
		);
	end

	// output register
	ccc_pkg::pair_t fp;
	logic signed [ccc_pkg::NormW-1:0] nx_c, ny_c;
	logic [ccc_pkg::NormW-1:0] qx_c, qy_c;

	always_comb begin
		fp   = dp[DivCells];
		qx_c = ddx[DivCells].quo[ccc_pkg::NormW-1:0];
		qy_c = ddy[DivCells].quo[ccc_pkg::NormW-1:0];
		nx_c = fp.sx ? qx_c : -qx_c;
		ny_c = fp.sy ? qy_c : -qy_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= fp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fp.coin) begin
				hit         <= 1'b1;
				normal_x    <= ccc_pkg::NormW'(-ccc_pkg::NormalOne);
				normal_y    <= ccc_pkg::NormW'(-ccc_pkg::NormalOne);
				penetration <= ccc_pkg::PenW'(ccc_pkg::CoinPen);
			end else if (fp.hit) begin
				hit         <= 1'b1;
				normal_x    <= nx_c;
				normal_y    <= ny_c;
				penetration <= ccc_pkg::PenW'(fp.rsum - ccc_pkg::RsumW'(dl[DivCells]));
			end else begin
				hit         <= 1'b0;
				normal_x    <= '0;
				normal_y    <= '0;
				penetration <= '0;
			end
		end
	end

endmodule

// ===== rtl/ccc_checker.sv =====
// ----------------------------------------------------------------------------
// ccc_port_checker: port-level checks for the circle collision block
// Watches the handshake and result encoding seen at the top-level ports.
// ----------------------------------------------------------------------------
module ccc_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [23:0] penetration
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(penetration))
		else $error("stalled result changed");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> normal_x == 0 && normal_y == 0 && penetration == 0)
		else $error("miss with nonzero payload");

	a_pen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> penetration != 0)
		else $error("hit with zero penetration");
endmodule

bind circle_circle_collision ccc_port_checker u_ccc_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .hit(hit), .normal_x(normal_x), .normal_y(normal_y),
	.penetration(penetration)
);

// ===== tb/sv/ccc_checker.sv =====
// ----------------------------------------------------------------------------
// ccc_checker: result predictor and scoreboard for circle_circle_collision
// Watches both channels, computes the expected hit, normal and depth for each
// accepted circle pair and compares them in order with accepted results.
// ----------------------------------------------------------------------------
module ccc_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [ccc_pkg::CoordW-1:0] a_left,
	input  logic signed [ccc_pkg::CoordW-1:0] a_top,
	input  logic [ccc_pkg::RadW-1:0]          a_radius,
	input  logic signed [ccc_pkg::CoordW-1:0] b_left,
	input  logic signed [ccc_pkg::CoordW-1:0] b_top,
	input  logic [ccc_pkg::RadW-1:0]          b_radius,
	input  logic out_valid,
	input  logic out_stall,
	input  logic hit,
	input  logic signed [ccc_pkg::NormW-1:0] normal_x,
	input  logic signed [ccc_pkg::NormW-1:0] normal_y,
	input  logic signed [ccc_pkg::PenW-1:0]  penetration,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                             hit;
		logic signed [ccc_pkg::NormW-1:0] nx;
		logic signed [ccc_pkg::NormW-1:0] ny;
		logic signed [ccc_pkg::PenW-1:0]  pen;
	} contact_t;

	contact_t contact_q[$];

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] push_comp(longint d, longint unsigned len);
		longint unsigned m;
		longint unsigned q;
		m = (d < 0) ? -d : d;
		q = (m * 32768 + len) / (2 * len);
		return (d < 0) ? 16'(q) : -16'(q);
	endfunction

	function automatic contact_t predict_contact(longint al, longint at, longint ar,
			longint bl, longint bt, longint br);
		contact_t c;
		longint dx, dy;
		longint unsigned s, rs, len;
		dx = (al + ar) - (bl + br);
		dy = (at + ar) - (bt + br);
		s = dx * dx + dy * dy;
		rs = ar + br;
		c = '0;
		if (s == 0) begin
			c.hit = 1'b1;
			c.nx = -16'(ccc_pkg::NormalOne);
			c.ny = -16'(ccc_pkg::NormalOne);
			c.pen = 24'(ccc_pkg::CoinPen);
		end else if (s < rs * rs) begin
			len = int_sqrt(s);
			c.hit = 1'b1;
			c.nx = push_comp(dx, len);
			c.ny = push_comp(dy, len);
			c.pen = 24'(rs - len);
		end
		return c;
	endfunction

	assign pending = contact_q.size();

	always @(posedge clk or negedge arst_n) begin
		contact_t e;
		contact_t got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				contact_q.push_back(predict_contact(a_left, a_top, a_radius,
					b_left, b_top, b_radius));
			if (out_valid && !out_stall) begin
				got = '{hit, normal_x, normal_y, penetration};
				if (contact_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %p", got);
					fail_count <= fail_count + 1;
				end else begin
					e = contact_q.pop_front();
					if (e !== got) begin
						if (fail_count < 10)
							$display("mismatch: expected %p actual %p", e, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/tb_circle_circle_collision.sv =====
// ----------------------------------------------------------------------------
// tb_circle_circle_collision: stimulus and verdict for the collision block
// Directed corner pairs, then random pairs biased toward near contact, with
// random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_circle_circle_collision;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandItems = 1300;
	localparam int WatchLimit = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
	logic signed [23:0] a_left = '0, a_top = '0, b_left = '0, b_top = '0;
	logic [21:0] a_radius = '0, b_radius = '0;
	logic hit;
	logic signed [15:0] normal_x, normal_y;
	logic signed [23:0] penetration;
	int fail_count, pending;
	bit  stim_done = 0;
	bit  calm = 0;
	int  idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	circle_circle_collision i_dut (.*);

	ccc_checker i_chk (.*);

	task automatic send_pair(logic [23:0] al, logic [23:0] at, logic [21:0] ar,
			logic [23:0] bl, logic [23:0] bt, logic [21:0] br);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_left <= al; a_top <= at; a_radius <= ar;
		b_left <= bl; b_top <= bt; b_radius <= br;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_coord();
		return 24'($urandom);
	endfunction

	// receiver: one long hold-off, then random bursts, calm at the end
	initial begin
		@(posedge arst_n);
		repeat (60) @(posedge clk);
		out_stall <= 1'b1;
		repeat (300) @(posedge clk);
		out_stall <= 1'b0;
		while (!calm) begin
			@(posedge clk);
			if (!out_stall && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [23:0] al, at, bl, bt;
		logic [21:0] ar, br;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: coincident, zero radii, extremes, touching, tiny offsets
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(24'h7FFFFF, 24'h7FFFFF, 22'h3FFFFF, 24'h7FFFFF, 24'h7FFFFF, 22'h3FFFFF);
		send_pair(24'h800000, 24'h800000, 0, 24'h7FFFFF, 24'h7FFFFF, 0);
		send_pair(24'h7FFFFF, 24'h800000, 22'h3FFFFF, 24'h800000, 24'h7FFFFF, 22'h3FFFFF);
		send_pair(24'h800000, 24'h800000, 22'h3FFFFF, 24'h800000, 24'h800000, 0);
		send_pair(0, 0, 100, 200, 0, 100);
		send_pair(0, 0, 100, 199, 0, 100);
		send_pair(0, 0, 100, 0, 199, 100);
		send_pair(0, 0, 100, 120, 160, 100);
		send_pair(0, 0, 100, 119, 160, 100);
		send_pair(0, 0, 1, 1, 0, 0);
		send_pair(0, 0, 1, 1, 1, 0);
		send_pair(0, 0, 0, 1, 1, 0);
		send_pair(5, 5, 0, 0, 0, 5);
		send_pair(24'hFFFFFF, 24'hFFFFFF, 22'h3FFFFF, 24'h000001, 24'h000001, 22'h3FFFFF);
		send_pair(24'h400000, 24'hC00000, 22'h200000, 24'hC00000, 24'h400000, 22'h1FFFFF);
		send_pair(300, 7, 50, 0, 0, 300);
		send_pair(24'hFFFF00, 24'h000100, 1000, 24'h000100, 24'hFFFF00, 1000);
		for (k = 0; k < RandItems; k++) begin
			if (k > RandItems * 9 / 10) calm = 1;
			ar = (k % 10 == 0) ? 22'($urandom) : 22'($urandom_range(0, 65535));
			br = (k % 10 == 0) ? 22'($urandom) : 22'($urandom_range(0, 65535));
			case ($urandom_range(0, 3))
				0: begin
					al = rand_coord(); at = rand_coord(); bl = rand_coord(); bt = rand_coord();
				end
				1: begin
					al = rand_coord(); at = rand_coord();
					bl = al + 24'($signed($urandom_range(0, 262143)) - 131072);
					bt = at + 24'($signed($urandom_range(0, 262143)) - 131072);
				end
				2: begin
					al = rand_coord(); at = rand_coord();
					bl = al + 24'(ar) - 24'(br) + 24'($signed($urandom_range(0, 8)) - 4);
					bt = at + 24'(ar) - 24'(br) + 24'($signed($urandom_range(0, 8)) - 4);
				end
				default: begin
					al = rand_coord(); at = rand_coord();
					bl = al + 24'($signed($urandom_range(0, 8191)) - 4096);
					bt = at + 24'($signed($urandom_range(0, 8191)) - 4096);
				end
			endcase
			send_pair(al, at, ar, bl, bt, br);
		end
		in_valid <= 1'b0;
		calm = 1;
		k = 0;
		while (pending != 0 && k < 20000) begin
			@(posedge clk);
			k++;
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0 && !out_valid) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
